>>> hdl/eeg_window_trend_detector_assert.svh
// Assertion macros shared by the EEG window trend detector modules.
`ifndef EEG_WINDOW_TREND_DETECTOR_ASSERT_SVH
`define EEG_WINDOW_TREND_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset.
`define EWTD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ewtd check failed: %m");

// Next-cycle implication, sampled on clk, off during reset.
`define EWTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ewtd check failed: %m");

`else

`define EWTD_ASSERT_SAME(lbl, ante, cons)
`define EWTD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/ewtd_pkg.sv
// Shared widths, constants, sample record and state codes of the trend detector.
package ewtd_pkg;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 7;
  localparam int QUAL_W     = 8;
  localparam int RATE_W     = 21;
  localparam int PCT_W      = 7;
  localparam int WEIGHT_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // Arithmetic constants
  localparam int RATE_SCALE = 16000;  // 1000 ms per s times 16 for the fraction
  localparam int PCT_FULL   = 100;
  localparam int SCORE_MAX  = 100;
  localparam int FRAC_BITS  = 4;
  localparam int PROD_W     = RATE_W + WEIGHT_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int SCORE_W    = SUM_W - FRAC_BITS + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BAD_QUALITY_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STABILITY_LIMIT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_RATE_LIMIT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_RATE_LIMIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTENTION_WEIGHT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FATIGUE_WEIGHT        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNSTABLE_PENALTY      = 3'd6;

  // One stored window entry
  typedef struct packed {
    logic [TIME_W-1:0]  time_ms;
    logic [LEVEL_W-1:0] attention_level;
    logic [LEVEL_W-1:0] fatigue_level;
    logic [QUAL_W-1:0]  quality_value;
    logic               link_up;
  } ewtd_sample_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DELTA,
    ST_WALK,
    ST_STAB,
    ST_DIV_WAIT,
    ST_MUL,
    ST_SCORE
  } ewtd_state_t;

endpackage

>>> hdl/ewtd_if.sv
// Channel interfaces of the trend detector: sample input, result output, register writes.
interface ewtd_in_if;
  import ewtd_pkg::*;
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  time_ms;
  logic [LEVEL_W-1:0] attention_level;
  logic [LEVEL_W-1:0] fatigue_level;
  logic [QUAL_W-1:0]  quality_value;
  logic               link_up;

  modport source (output valid, time_ms, attention_level, fatigue_level, quality_value,
                  link_up, input ready);
  modport sink (input valid, time_ms, attention_level, fatigue_level, quality_value,
                link_up, output ready);
endinterface

interface ewtd_out_if;
  import ewtd_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] attention_drop_rate;
  logic [RATE_W-1:0] fatigue_rise_rate;
  logic [PCT_W-1:0]  stability_percent;
  logic              unstable_flag;
  logic              consciousness_drop_flag;
  logic [PCT_W-1:0]  trend_level;

  modport source (output valid, attention_drop_rate, fatigue_rise_rate, stability_percent,
                  unstable_flag, consciousness_drop_flag, trend_level, input ready);
  modport sink (input valid, attention_drop_rate, fatigue_rise_rate, stability_percent,
                unstable_flag, consciousness_drop_flag, trend_level, output ready);
endinterface

interface ewtd_cfg_if;
  import ewtd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/ewtd_window_ram.sv
// Sample window memory: one write port, one read port with registered data.
module ewtd_window_ram #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr_i,
  input  ewtd_pkg::ewtd_sample_t      wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr_i,
  output ewtd_pkg::ewtd_sample_t      rd_data_o
);
  import ewtd_pkg::*;

  ewtd_sample_t mem_r [DEPTH];
  ewtd_sample_t rd_data_r;

  // Store a new sample
  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem_r[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry a cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr_i];
  end

  assign rd_data_o = rd_data_r;

endmodule

>>> hdl/ewtd_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
`include "eeg_window_trend_detector_assert.svh"

module ewtd_serial_div #(
  parameter int DIVIDEND_W = 21,
  parameter int DIVISOR_W  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);
  import ewtd_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  den_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  // Control: run DIVIDEND_W steps after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      den_r <= divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done_o     = done_r;
  assign quotient_o = quo_r;

  `EWTD_ASSERT_SAME(a_busy_done_excl, 1'b1, !(busy_r && done_r))
  `EWTD_ASSERT_NEXT(a_start_busy, start_i, busy_r && !done_r)
  `EWTD_ASSERT_NEXT(a_last_done, busy_r && !start_i && cnt_r == CNT_W'(DIVIDEND_W - 1), done_r)

endmodule

>>> hdl/eeg_window_trend_detector.sv
// Top level of the EEG window trend detector: register file, sequencer and result stage.
//
//   channel  dir  handshake              payload
//   in_ch    in   in_ch.valid/ready      time_ms, attention/fatigue level, quality, link_up
//   out_ch   out  out_ch.valid/ready     drop/rise rates, stability, flags, trend score
//   cfg_ch   in   cfg_ch.valid/ready     index, data (ready always high)
//
// A kept sample runs the RAM walk over the fill held entries, fill counting the new one,
// then the serial stability division, while the 21-step rate divisions run alongside from
// the start of the walk. A zero-time sample is dropped; the first one is only stored.
// Reset (synchronous, rst_n low) empties the window and loads the register defaults.
// The result sits in an output register; a new sample is taken while it waits, and only
// the final load stalls until out_ch takes the previous result.
`include "eeg_window_trend_detector_assert.svh"

module eeg_window_trend_detector #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ewtd_in_if.sink   in_ch,
  ewtd_out_if.source out_ch,
  ewtd_cfg_if.sink  cfg_ch
);
  import ewtd_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int STAB_W = CNT_W + PCT_W;

  // Configuration registers
  logic [QUAL_W-1:0]   bad_thr_r;
  logic [PCT_W-1:0]    stab_lim_r;
  logic [RATE_W-1:0]   drop_lim_r;
  logic [RATE_W-1:0]   rise_lim_r;
  logic [WEIGHT_W-1:0] att_w_r;
  logic [WEIGHT_W-1:0] fat_w_r;
  logic [PCT_W-1:0]    penalty_r;

  // Sequencer
  ewtd_state_t state_r;
  ewtd_state_t state_nxt;
  logic        in_ready;
  logic        wr_en;
  logic        rate_start;
  logic        stab_start;
  logic        out_load;
  logic        walk_last;
  logic [PTR_W-1:0] rd_addr;

  // Window bookkeeping
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] wp_inc;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_sat;
  logic [PTR_W-1:0] old_idx_r;
  logic [CNT_W-1:0] walk_r;
  logic [CNT_W-1:0] bad_r;

  // Newest sample
  logic [TIME_W-1:0]  new_time_r;
  logic [LEVEL_W-1:0] new_att_r;
  logic [LEVEL_W-1:0] new_fat_r;

  ewtd_sample_t wr_sample;
  ewtd_sample_t rd_sample;

  // Divider operands and results
  logic [TIME_W-1:0]  dt;
  logic [LEVEL_W-1:0] att_drop;
  logic [LEVEL_W-1:0] fat_delta;
  logic [RATE_W-1:0]  att_dividend;
  logic [RATE_W-1:0]  fat_dividend;
  logic [STAB_W-1:0]  stab_dividend;
  logic [RATE_W-1:0]  adr_q;
  logic [RATE_W-1:0]  frr_q;
  logic [STAB_W-1:0]  stab_q;
  logic               adr_done;
  logic               frr_done;
  logic               stab_done;
  logic               is_bad;

  // Score stage
  logic [PROD_W-1:0]  adr_prod_r;
  logic [PROD_W-1:0]  frr_prod_r;
  logic [PCT_W-1:0]   stab_pct_r;
  logic               unstable_r;
  logic [SUM_W-1:0]   prod_sum;
  logic [SCORE_W-1:0] score_full;
  logic [PCT_W-1:0]   score;

  // Output register
  logic               out_valid_r;
  logic [RATE_W-1:0]  adr_out_r;
  logic [RATE_W-1:0]  frr_out_r;
  logic [PCT_W-1:0]   stab_out_r;
  logic               unstable_out_r;
  logic               cdrop_out_r;
  logic [PCT_W-1:0]   score_out_r;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_thr_r  <= QUAL_W'(50);
      stab_lim_r <= PCT_W'(60);
      drop_lim_r <= RATE_W'(96);
      rise_lim_r <= RATE_W'(16);
      att_w_r    <= WEIGHT_W'(6);
      fat_w_r    <= WEIGHT_W'(4);
      penalty_r  <= PCT_W'(15);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BAD_QUALITY_THRESHOLD: bad_thr_r  <= cfg_ch.data[QUAL_W-1:0];
        REG_STABILITY_LIMIT:       stab_lim_r <= cfg_ch.data[PCT_W-1:0];
        REG_DROP_RATE_LIMIT:       drop_lim_r <= cfg_ch.data[RATE_W-1:0];
        REG_RISE_RATE_LIMIT:       rise_lim_r <= cfg_ch.data[RATE_W-1:0];
        REG_ATTENTION_WEIGHT:      att_w_r    <= cfg_ch.data[WEIGHT_W-1:0];
        REG_FATIGUE_WEIGHT:        fat_w_r    <= cfg_ch.data[WEIGHT_W-1:0];
        REG_UNSTABLE_PENALTY:      penalty_r  <= cfg_ch.data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pointer and fill arithmetic
  assign wp_inc    = (wp_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
  assign fill_sat  = (fill_r == CNT_W'(WINDOW_DEPTH)) ? fill_r : fill_r + CNT_W'(1);
  assign walk_last = (walk_r == fill_r - CNT_W'(1));

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and sequencer strobes
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    wr_en      = 1'b0;
    rate_start = 1'b0;
    stab_start = 1'b0;
    out_load   = 1'b0;
    rd_addr    = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid && in_ch.time_ms != '0) begin
          wr_en = 1'b1;
          if (fill_r != '0) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        rd_addr   = old_idx_r;
        state_nxt = ST_DELTA;
      end
      ST_DELTA: begin
        rate_start = 1'b1;
        state_nxt  = ST_WALK;
      end
      ST_WALK: begin
        if (walk_last) begin
          state_nxt = ST_STAB;
        end else begin
          rd_addr = walk_r[PTR_W-1:0] + PTR_W'(1);
        end
      end
      ST_STAB: begin
        stab_start = 1'b1;
        state_nxt  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (adr_done && frr_done && stab_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SCORE;
      end
      ST_SCORE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = in_ready;

  // Window control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (wr_en) begin
      wp_r   <= wp_inc;
      fill_r <= fill_sat;
    end
  end

  // Capture the newest sample and locate the oldest
  always_ff @(posedge clk) begin
    if (wr_en) begin
      new_time_r <= in_ch.time_ms;
      new_att_r  <= in_ch.attention_level;
      new_fat_r  <= in_ch.fatigue_level;
      old_idx_r  <= (fill_sat == CNT_W'(WINDOW_DEPTH)) ? wp_inc : '0;
    end
  end

  assign wr_sample.time_ms         = in_ch.time_ms;
  assign wr_sample.attention_level = in_ch.attention_level;
  assign wr_sample.fatigue_level   = in_ch.fatigue_level;
  assign wr_sample.quality_value   = in_ch.quality_value;
  assign wr_sample.link_up         = in_ch.link_up;

  ewtd_window_ram #(
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en_i   (wr_en),
    .wr_addr_i (wp_r),
    .wr_data_i (wr_sample),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_sample)
  );

  // Time step and level changes against the oldest sample
  always_comb begin
    dt = (new_time_r > rd_sample.time_ms) ? new_time_r - rd_sample.time_ms : TIME_W'(1);
    att_drop = (rd_sample.attention_level > new_att_r) ?
               rd_sample.attention_level - new_att_r : '0;
    fat_delta = (new_fat_r > rd_sample.fatigue_level) ?
                new_fat_r - rd_sample.fatigue_level : '0;
    att_dividend  = RATE_W'(att_drop) * RATE_W'(RATE_SCALE);
    fat_dividend  = RATE_W'(fat_delta) * RATE_W'(RATE_SCALE);
    stab_dividend = STAB_W'(bad_r) * STAB_W'(PCT_FULL);
  end

  ewtd_serial_div #(
    .DIVIDEND_W (RATE_W),
    .DIVISOR_W  (TIME_W)
  ) u_adr_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (rate_start),
    .dividend_i (att_dividend),
    .divisor_i  (dt),
    .done_o     (adr_done),
    .quotient_o (adr_q)
  );

  ewtd_serial_div #(
    .DIVIDEND_W (RATE_W),
    .DIVISOR_W  (TIME_W)
  ) u_frr_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (rate_start),
    .dividend_i (fat_dividend),
    .divisor_i  (dt),
    .done_o     (frr_done),
    .quotient_o (frr_q)
  );

  ewtd_serial_div #(
    .DIVIDEND_W (STAB_W),
    .DIVISOR_W  (CNT_W)
  ) u_stab_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (stab_start),
    .dividend_i (stab_dividend),
    .divisor_i  (fill_r),
    .done_o     (stab_done),
    .quotient_o (stab_q)
  );

  // Walk the window one entry a cycle and count bad samples
  assign is_bad = (rd_sample.quality_value >= bad_thr_r) || !rd_sample.link_up;

  always_ff @(posedge clk) begin
    if (state_r == ST_DELTA) begin
      walk_r <= '0;
      bad_r  <= '0;
    end else if (state_r == ST_WALK) begin
      walk_r <= walk_r + CNT_W'(1);
      bad_r  <= bad_r + CNT_W'(is_bad);
    end
  end

  // Weight the rates and finish the stability figure
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      adr_prod_r <= PROD_W'(adr_q) * PROD_W'(att_w_r);
      frr_prod_r <= PROD_W'(frr_q) * PROD_W'(fat_w_r);
      stab_pct_r <= PCT_W'(PCT_FULL) - stab_q[PCT_W-1:0];
      unstable_r <= (PCT_W'(PCT_FULL) - stab_q[PCT_W-1:0]) < stab_lim_r;
    end
  end

  // Sum, drop the fraction, add the penalty and clamp
  always_comb begin
    prod_sum   = SUM_W'(adr_prod_r) + SUM_W'(frr_prod_r);
    score_full = SCORE_W'(prod_sum[SUM_W-1:FRAC_BITS]) +
                 (unstable_r ? SCORE_W'(penalty_r) : '0);
    score      = (score_full > SCORE_W'(SCORE_MAX)) ? PCT_W'(SCORE_MAX) :
                 score_full[PCT_W-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      adr_out_r      <= adr_q;
      frr_out_r      <= frr_q;
      stab_out_r     <= stab_pct_r;
      unstable_out_r <= unstable_r;
      cdrop_out_r    <= (adr_q >= drop_lim_r) && (frr_q >= rise_lim_r);
      score_out_r    <= score;
    end
  end

  assign out_ch.valid                   = out_valid_r;
  assign out_ch.attention_drop_rate     = adr_out_r;
  assign out_ch.fatigue_rise_rate       = frr_out_r;
  assign out_ch.stability_percent       = stab_out_r;
  assign out_ch.unstable_flag           = unstable_out_r;
  assign out_ch.consciousness_drop_flag = cdrop_out_r;
  assign out_ch.trend_level             = score_out_r;

  `EWTD_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= CNT_W'(WINDOW_DEPTH))
  `EWTD_ASSERT_SAME(a_walk_range, state_r == ST_WALK, walk_r < fill_r)
  `EWTD_ASSERT_NEXT(a_out_source, !out_valid_r && state_r != ST_SCORE, !out_valid_r)
  `EWTD_ASSERT_NEXT(a_second_sample, wr_en && fill_r != '0, state_r == ST_FETCH)

endmodule

>>> sim/eeg_window_trend_detector_test.sv
// Self-checking testbench for the EEG window trend detector: directed and random samples.
`timescale 1ns / 1ps

module eeg_window_trend_detector_test;
  import ewtd_pkg::*;

  localparam int WINDOW_DEPTH  = 16;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 300;
  localparam int PRINT_LIMIT   = 40;
  localparam int LIMIT_NS      = 2_000_000;

  // Index past the last register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // One trend result as the block reports it
  typedef struct packed {
    logic [RATE_W-1:0] drop_rate;
    logic [RATE_W-1:0] rise_rate;
    logic [PCT_W-1:0]  stability;
    logic              unstable;
    logic              cdrop;
    logic [PCT_W-1:0]  score;
  } trend_t;

  // Window copy, register copy and the queue of trends still owed by the block
  class trend_tracker;
    ewtd_sample_t        window [WINDOW_DEPTH];
    int unsigned         wr_ptr;
    int unsigned         fill;
    logic [QUAL_W-1:0]   bad_thr;
    logic [PCT_W-1:0]    stab_limit;
    logic [RATE_W-1:0]   drop_limit;
    logic [RATE_W-1:0]   rise_limit;
    logic [WEIGHT_W-1:0] att_weight;
    logic [WEIGHT_W-1:0] fat_weight;
    logic [PCT_W-1:0]    penalty;
    trend_t              pending_trends [$];
    int unsigned         samples_taken;
    int unsigned         trends_checked;
    int unsigned         errors;

    function new();
      wr_ptr         = 0;
      fill           = 0;
      samples_taken  = 0;
      trends_checked = 0;
      errors         = 0;
      bad_thr        = QUAL_W'(50);
      stab_limit     = PCT_W'(60);
      drop_limit     = RATE_W'(96);
      rise_limit     = RATE_W'(16);
      att_weight     = WEIGHT_W'(6);
      fat_weight     = WEIGHT_W'(4);
      penalty        = PCT_W'(15);
    endfunction

    // Mirror one register write; unknown indexes are dropped
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BAD_QUALITY_THRESHOLD: bad_thr    = data[QUAL_W-1:0];
        REG_STABILITY_LIMIT:       stab_limit = data[PCT_W-1:0];
        REG_DROP_RATE_LIMIT:       drop_limit = data[RATE_W-1:0];
        REG_RISE_RATE_LIMIT:       rise_limit = data[RATE_W-1:0];
        REG_ATTENTION_WEIGHT:      att_weight = data[WEIGHT_W-1:0];
        REG_FATIGUE_WEIGHT:        fat_weight = data[WEIGHT_W-1:0];
        REG_UNSTABLE_PENALTY:      penalty    = data[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    // Level change per second in sixteenths, truncated
    function longint unsigned per_second(int unsigned delta, logic [TIME_W-1:0] span);
      longint unsigned scaled;
      scaled = 64'(delta) * 64'(RATE_SCALE);
      return (scaled / 64'(span)) & ((64'd1 << RATE_W) - 1);
    endfunction

    // Store an accepted sample and queue the trend it yields, if any
    function void take_sample(ewtd_sample_t s);
      int unsigned       newest, oldest, bad, stab;
      logic [TIME_W-1:0] span;
      longint unsigned   drop, rise, score;
      ewtd_sample_t      o, n;
      trend_t            t;
      if (s.time_ms == '0) return;
      samples_taken++;
      newest = wr_ptr;
      window[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % WINDOW_DEPTH;
      if (fill < WINDOW_DEPTH) fill++;
      if (fill < 2) return;
      oldest = (wr_ptr + WINDOW_DEPTH - fill) % WINDOW_DEPTH;
      o = window[oldest];
      n = window[newest];

      // Non-increasing time counts as one millisecond
      span = (n.time_ms > o.time_ms) ? n.time_ms - o.time_ms : 1;
      drop = (o.attention_level > n.attention_level) ?
             per_second(o.attention_level - n.attention_level, span) : 0;
      rise = (n.fatigue_level > o.fatigue_level) ?
             per_second(n.fatigue_level - o.fatigue_level, span) : 0;

      // Count bad entries among those held
      bad = 0;
      for (int i = 0; i < fill; i++)
        if (window[i].quality_value >= bad_thr || !window[i].link_up) bad++;
      stab = PCT_FULL - (bad * PCT_FULL) / fill;

      t.drop_rate = RATE_W'(drop);
      t.rise_rate = RATE_W'(rise);
      t.stability = PCT_W'(stab);
      t.unstable  = (stab < stab_limit);
      t.cdrop     = (drop >= drop_limit) && (rise >= rise_limit);
      score = (drop * att_weight + rise * fat_weight) >> FRAC_BITS;
      if (t.unstable) score += penalty;
      if (score > SCORE_MAX) score = SCORE_MAX;
      t.score = PCT_W'(score);
      pending_trends.push_back(t);
    endfunction

    task report(string line);
      errors++;
      if (errors <= PRINT_LIMIT) $display("%0t: mismatch: %s", $time, line);
    endtask

    // Compare one result transaction against the oldest owed trend
    task check_trend(trend_t got);
      trend_t want;
      trends_checked++;
      if (pending_trends.size() == 0) begin
        report($sformatf("result %0d arrived with no trend owed", trends_checked));
        return;
      end
      want = pending_trends.pop_front();
      if (got.drop_rate != want.drop_rate)
        report($sformatf("attention_drop_rate got %0d expected %0d",
                         got.drop_rate, want.drop_rate));
      if (got.rise_rate != want.rise_rate)
        report($sformatf("fatigue_rise_rate got %0d expected %0d",
                         got.rise_rate, want.rise_rate));
      if (got.stability != want.stability)
        report($sformatf("stability_percent got %0d expected %0d",
                         got.stability, want.stability));
      if (got.unstable != want.unstable)
        report($sformatf("unstable_flag got %0d expected %0d", got.unstable, want.unstable));
      if (got.cdrop != want.cdrop)
        report($sformatf("consciousness_drop_flag got %0d expected %0d",
                         got.cdrop, want.cdrop));
      if (got.score != want.score)
        report($sformatf("trend_level got %0d expected %0d", got.score, want.score));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ewtd_in_if  in_ch ();
  ewtd_out_if out_ch ();
  ewtd_cfg_if cfg_ch ();

  trend_tracker tracker = new();

  int unsigned       in_idle_pct  = 26;
  int unsigned       out_idle_pct = 78;
  logic [TIME_W-1:0] run_ms;

  eeg_window_trend_detector #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check each result transaction and redraw ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_trend('{drop_rate: out_ch.attention_drop_rate,
                            rise_rate: out_ch.fatigue_rise_rate,
                            stability: out_ch.stability_percent,
                            unstable:  out_ch.unstable_flag,
                            cdrop:     out_ch.consciousness_drop_flag,
                            score:     out_ch.trend_level});
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic ewtd_sample_t make_sample(logic [TIME_W-1:0] t, logic [LEVEL_W-1:0] a,
                                               logic [LEVEL_W-1:0] f, logic [QUAL_W-1:0] q,
                                               logic l);
    ewtd_sample_t s;
    s.time_ms         = t;
    s.attention_level = a;
    s.fatigue_level   = f;
    s.quality_value   = q;
    s.link_up         = l;
    return s;
  endfunction

  // Mostly rising time with short steps, plus zero, repeated or earlier, and jumping timestamps
  function automatic ewtd_sample_t random_sample();
    ewtd_sample_t s;
    int unsigned  pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      s.time_ms = '0;
    end else if (pick < 10) begin
      run_ms = $urandom;
      s.time_ms = run_ms;
    end else if (pick < 16) begin
      s.time_ms = run_ms - $urandom_range(500, 0);
    end else begin
      run_ms += ($urandom_range(99) < 70) ? $urandom_range(40, 1) : $urandom_range(3000, 41);
      s.time_ms = run_ms;
    end
    s.attention_level = ($urandom_range(99) < 12) ? LEVEL_W'($urandom_range(127, 101))
                                                  : LEVEL_W'($urandom_range(100, 0));
    s.fatigue_level   = ($urandom_range(99) < 12) ? LEVEL_W'($urandom_range(127, 101))
                                                  : LEVEL_W'($urandom_range(100, 0));
    s.quality_value   = ($urandom_range(1) != 0) ? QUAL_W'($urandom_range(255, 0))
                                                 : QUAL_W'(tracker.bad_thr +
                                                           $urandom_range(4, 0) - 2);
    s.link_up         = ($urandom_range(99) < 85);
    return s;
  endfunction

  // Offer one sample after a random gap; hold valid high when there is no gap
  task automatic send_sample(ewtd_sample_t s);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.time_ms         <= s.time_ms;
    in_ch.attention_level <= s.attention_level;
    in_ch.fatigue_level   <= s.fatigue_level;
    in_ch.quality_value   <= s.quality_value;
    in_ch.link_up         <= s.link_up;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_sample(s);
  endtask

  // Count only samples the block keeps
  task automatic run_random(int unsigned count);
    int unsigned  kept;
    ewtd_sample_t s;
    kept = 0;
    while (kept < count) begin
      s = random_sample();
      send_sample(s);
      if (s.time_ms != '0) kept++;
    end
  endtask

  // Hold the input until every owed trend has come, then optionally let the block settle
  task automatic wait_results(bit settle);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_trends.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; valid stays high for a following write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  task automatic apply_settings(int unsigned bad, int unsigned stab, int unsigned drop,
                                int unsigned rise, int unsigned aw, int unsigned fw,
                                int unsigned pen);
    cfg_write(REG_BAD_QUALITY_THRESHOLD, CFG_DATA_W'(bad));
    cfg_write(REG_STABILITY_LIMIT, CFG_DATA_W'(stab));
    cfg_write(REG_DROP_RATE_LIMIT, CFG_DATA_W'(drop));
    cfg_write(REG_RISE_RATE_LIMIT, CFG_DATA_W'(rise));
    cfg_write(REG_ATTENTION_WEIGHT, CFG_DATA_W'(aw));
    cfg_write(REG_FATIGUE_WEIGHT, CFG_DATA_W'(fw));
    cfg_write(REG_UNSTABLE_PENALTY, CFG_DATA_W'(pen));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_random_settings();
    apply_settings($urandom_range(255, 0), $urandom_range(100, 0), $urandom_range(4000, 0),
                   $urandom_range(4000, 0), $urandom_range(15, 0), $urandom_range(15, 0),
                   $urandom_range(100, 0));
  endtask

  // Stimulus sequence
  initial begin
    int unsigned k;
    in_ch.valid           <= 1'b0;
    in_ch.time_ms         <= '0;
    in_ch.attention_level <= '0;
    in_ch.fatigue_level   <= '0;
    in_ch.quality_value   <= '0;
    in_ch.link_up         <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= '0;
    cfg_ch.data           <= '0;
    run_ms = 32'd5000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples at the reset register values
    send_sample(make_sample(32'd0, 7'd127, 7'd127, 8'd255, 1'b1));   // zero time, dropped
    send_sample(make_sample(32'd1000, 7'd100, 7'd0, 8'd0, 1'b1));    // first held, no result
    send_sample(make_sample(32'd1000, 7'd0, 7'd100, 8'd49, 1'b1));   // equal time
    send_sample(make_sample(32'd400, 7'd127, 7'd0, 8'd50, 1'b1));    // time goes back
    send_sample(make_sample(32'd401, 7'd0, 7'd127, 8'd255, 1'b0));   // link down
    send_sample(make_sample(32'hFFFF_FFFF, 7'd0, 7'd0, 8'd0, 1'b0));
    send_sample(make_sample(32'd0, 7'd50, 7'd50, 8'd10, 1'b1));      // dropped mid-window
    send_sample(make_sample(32'h8000_0000, 7'd127, 7'd127, 8'd255, 1'b1));
    // Wrap the window with a steady attention fall and fatigue rise
    for (k = 0; k < 16; k++)
      send_sample(make_sample(TIME_W'(2000 + k * 125), LEVEL_W'(100 - 6 * k),
                              LEVEL_W'(5 * k), QUAL_W'(k * 37), (k % 5) != 0));
    wait_results(1'b1);

    // Top register values, sender idles lightly, receiver heavily
    cfg_write(REG_UNUSED, '1);
    apply_settings(255, 100, 1600000, 1600000, 15, 15, 100);
    run_random(RANDOM_ITEMS);
    wait_results(1'b1);

    // Bottom register values, idling swapped
    in_idle_pct  = 78;
    out_idle_pct = 26;
    apply_settings(0, 0, 0, 0, 0, 0, 0);
    run_random(RANDOM_ITEMS);
    wait_results(1'b1);

    // Random register values; drain the block halfway through
    apply_random_settings();
    run_random(RANDOM_ITEMS / 2);
    wait_results(1'b0);
    run_random(RANDOM_ITEMS / 2);
    wait_results(1'b1);

    // Random register values, no idling on either side
    in_idle_pct  = 0;
    out_idle_pct = 0;
    apply_random_settings();
    run_random(RANDOM_ITEMS);
    wait_results(1'b1);

    $display("covered %0d kept samples and %0d checked results", tracker.samples_taken,
             tracker.trends_checked);
    $display("over five register settings and three idle patterns, %0d mismatches",
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("eeg_window_trend_detector_test: done, clean");
    end else begin
      $display("eeg_window_trend_detector_test: done, errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(LIMIT_NS);
    $display("eeg_window_trend_detector_test: done, errors");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/ewtd_pkg.sv
hdl/ewtd_if.sv
hdl/ewtd_window_ram.sv
hdl/ewtd_serial_div.sv
hdl/eeg_window_trend_detector.sv
sim/eeg_window_trend_detector_test.sv
